[rtl/lpsc_pkg.sv]
// ----------------------------------------------------------------------------
// lpsc_pkg
// Shared types and constants for the length-prefixed to start-code converter.
// ----------------------------------------------------------------------------
package lpsc_pkg;

    localparam int HEAD_BYTES  = 4;
    localparam int HEAD_IDX_W  = $clog2(HEAD_BYTES);
    localparam int LENGTH_BITS = 32;
    localparam int PFX_CNT_W   = 3;
    localparam int CFG_W       = 3;

    localparam logic [PFX_CNT_W-1:0] PFX_MIN = PFX_CNT_W'(1);
    localparam logic [PFX_CNT_W-1:0] PFX_MAX = PFX_CNT_W'(4);
    localparam logic [CFG_W-1:0]     CFG_RESET = CFG_W'(4);

    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;

    typedef enum logic [2:0] {
        PH_HEAD,
        PH_PASS,
        PH_PREFIX,
        PH_PAYLOAD,
        PH_DISCARD
    } phase_t;

    // one request from the engine towards the output stage
    typedef struct packed {
        logic       push;
        logic       park;
        logic [7:0] data;
        logic       sample_end;
        logic       sample_error;
    } lpsc_res_t;

endpackage

[rtl/lpsc_engine.sv]
// ----------------------------------------------------------------------------
// lpsc_engine
// Holds one input byte, tracks the sample head, length prefixes and payload,
// and produces at most one output request per cycle.
// ----------------------------------------------------------------------------
module lpsc_engine
    import lpsc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_data_in,
    input  logic                 s_last_in,
    input  logic [PFX_CNT_W-1:0] pfx_size,
    input  logic                 out_free,
    output lpsc_res_t            res
);

    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_data_reg;
    logic                   in_last_reg;
    phase_t                 phase_reg, phase_next;
    logic [7:0]             head_reg [HEAD_BYTES];
    logic [HEAD_IDX_W-1:0]  head_cnt_reg, head_cnt_next;
    logic [PFX_CNT_W-1:0]   pfx_cnt_reg, pfx_cnt_next;
    logic [LENGTH_BITS-1:0] unit_len_reg, unit_len_next;
    logic [LENGTH_BITS-1:0] pay_left_reg, pay_left_next;
    logic                   rp_act_reg, rp_act_next;
    logic [HEAD_IDX_W-1:0]  rp_idx_reg, rp_idx_next;
    logic [1:0]             sc_left_reg, sc_left_next;
    logic                   flush_reg, flush_next;

    logic [7:0]             src;
    logic                   step_en;
    logic                   has_out;
    logic [7:0]             out_byte;
    logic                   adv;
    logic                   go;
    logic                   done;
    logic                   release_item;
    logic                   head_we;
    logic                   sc_hit;
    logic                   top_busy;
    logic [LENGTH_BITS-1:0] ul_shift;
    logic [PFX_CNT_W-1:0]   pc_inc;
    logic                   pfx_done;
    logic                   end_err;

    // replayed head bytes are fed through the same path as live bytes
    assign src      = rp_act_reg ? head_reg[rp_idx_reg] : in_data_reg;
    assign step_en  = in_valid_reg && !flush_reg;
    assign top_busy = unit_len_reg[LENGTH_BITS-1 -: 8] != 8'h00;
    assign ul_shift = {unit_len_reg[LENGTH_BITS-9:0], src};
    assign pc_inc   = pfx_cnt_reg + PFX_CNT_W'(1);
    assign pfx_done = pc_inc >= pfx_size;
    assign sc_hit   = head_reg[0] == 8'h00 && head_reg[1] == 8'h00 &&
                      (head_reg[2] == 8'h01 ||
                       (head_reg[2] == 8'h00 && in_data_reg == 8'h01));

    // result of the current step
    always_comb begin
        has_out  = 1'b0;
        out_byte = 8'h00;
        adv      = 1'b0;
        if (step_en) begin
            if (sc_left_reg != 2'd0) begin
                has_out  = 1'b1;
                out_byte = (sc_left_reg == 2'd1) ? SC_ONE : SC_ZERO;
                adv      = sc_left_reg == 2'd1;
            end else begin
                case (phase_reg)
                    PH_HEAD: begin
                        adv = head_cnt_reg != HEAD_IDX_W'(HEAD_BYTES - 1);
                    end
                    PH_PASS, PH_PAYLOAD: begin
                        has_out  = 1'b1;
                        out_byte = src;
                        adv      = 1'b1;
                    end
                    PH_PREFIX: begin
                        if (!top_busy && pfx_done && ul_shift != '0) begin
                            // first start code byte goes out with the prefix byte
                            has_out  = 1'b1;
                            out_byte = SC_ZERO;
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    default: begin
                        adv = 1'b1;
                    end
                endcase
            end
        end
    end

    assign go      = !has_out || out_free;
    assign done    = adv && (!rp_act_reg || rp_idx_reg == HEAD_IDX_W'(HEAD_BYTES - 1));
    assign head_we = step_en && sc_left_reg == 2'd0 && phase_reg == PH_HEAD;
    assign release_item = (step_en && go && done && !in_last_reg) || (flush_reg && out_free);
    assign s_ready = !in_valid_reg || release_item;

    assign end_err = phase_reg == PH_HEAD || phase_reg == PH_DISCARD ||
                     (phase_reg == PH_PREFIX && pfx_cnt_reg != '0) ||
                     (phase_reg == PH_PAYLOAD && pay_left_reg != '0);

    // request towards the output stage
    always_comb begin
        res.push         = (step_en && has_out && go) || (flush_reg && out_free);
        res.park         = in_last_reg && !flush_reg;
        res.data         = out_byte;
        res.sample_end   = flush_reg;
        res.sample_error = flush_reg && end_err;
    end

    // next state
    always_comb begin
        in_valid_next = in_valid_reg;
        phase_next    = phase_reg;
        head_cnt_next = head_cnt_reg;
        pfx_cnt_next  = pfx_cnt_reg;
        unit_len_next = unit_len_reg;
        pay_left_next = pay_left_reg;
        rp_act_next   = rp_act_reg;
        rp_idx_next   = rp_idx_reg;
        sc_left_next  = sc_left_reg;
        flush_next    = flush_reg;

        if (flush_reg && out_free) begin
            phase_next    = PH_HEAD;
            head_cnt_next = '0;
            pfx_cnt_next  = '0;
            unit_len_next = '0;
            pay_left_next = '0;
            rp_act_next   = 1'b0;
            rp_idx_next   = '0;
            sc_left_next  = 2'd0;
            flush_next    = 1'b0;
        end else if (step_en && go) begin
            if (sc_left_reg != 2'd0) begin
                sc_left_next = sc_left_reg - 2'd1;
            end else begin
                case (phase_reg)
                    PH_HEAD: begin
                        if (head_cnt_reg == HEAD_IDX_W'(HEAD_BYTES - 1)) begin
                            phase_next    = sc_hit ? PH_PASS : PH_PREFIX;
                            pfx_cnt_next  = '0;
                            unit_len_next = '0;
                            rp_act_next   = 1'b1;
                            rp_idx_next   = '0;
                        end else begin
                            head_cnt_next = head_cnt_reg + HEAD_IDX_W'(1);
                        end
                    end
                    PH_PREFIX: begin
                        if (top_busy) begin
                            phase_next = PH_DISCARD;
                        end else if (!pfx_done) begin
                            unit_len_next = ul_shift;
                            pfx_cnt_next  = pc_inc;
                        end else if (ul_shift == '0) begin
                            phase_next = PH_DISCARD;
                        end else begin
                            pay_left_next = ul_shift;
                            unit_len_next = '0;
                            pfx_cnt_next  = '0;
                            sc_left_next  = 2'd3;
                            phase_next    = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        pay_left_next = pay_left_reg - LENGTH_BITS'(1);
                        if (pay_left_reg == LENGTH_BITS'(1)) begin
                            phase_next = PH_PREFIX;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (adv && rp_act_reg) begin
                rp_idx_next = rp_idx_reg + HEAD_IDX_W'(1);
                if (rp_idx_reg == HEAD_IDX_W'(HEAD_BYTES - 1)) begin
                    rp_act_next = 1'b0;
                end
            end
            // the last byte of a sample then gets a flush step to attach the end flags
            if (done && in_last_reg) begin
                flush_next = 1'b1;
            end
        end

        if (release_item) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_HEAD;
            head_cnt_reg <= '0;
            pfx_cnt_reg  <= '0;
            unit_len_reg <= '0;
            pay_left_reg <= '0;
            rp_act_reg   <= 1'b0;
            rp_idx_reg   <= '0;
            sc_left_reg  <= 2'd0;
            flush_reg    <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            phase_reg    <= phase_next;
            head_cnt_reg <= head_cnt_next;
            pfx_cnt_reg  <= pfx_cnt_next;
            unit_len_reg <= unit_len_next;
            pay_left_reg <= pay_left_next;
            rp_act_reg   <= rp_act_next;
            rp_idx_reg   <= rp_idx_next;
            sc_left_reg  <= sc_left_next;
            flush_reg    <= flush_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_in;
            in_last_reg <= s_last_in;
        end
        if (head_we) begin
            head_reg[head_cnt_reg] <= in_data_reg;
        end
    end

    a_sc_in_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        sc_left_reg != 2'd0 |-> phase_reg == PH_PAYLOAD)
        else $error("start code pending outside payload phase");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> !flush_reg && sc_left_reg == 2'd0 && !rp_act_reg)
        else $error("sequencing state left over with no byte held");

    a_replay_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        rp_act_reg |-> phase_reg != PH_HEAD)
        else $error("head replay while still collecting the head");

    a_flush_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_reg |-> in_last_reg && !rp_act_reg && sc_left_reg == 2'd0)
        else $error("end flush with work still outstanding");

endmodule

[rtl/lpsc_out_stage.sv]
// ----------------------------------------------------------------------------
// lpsc_out_stage
// Output register plus a one-byte holding slot so the end flags of a sample
// land on its final byte.
// ----------------------------------------------------------------------------
module lpsc_out_stage
    import lpsc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  lpsc_res_t  res,
    output logic       out_free,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_out,
    output logic       m_data_valid,
    output logic       m_sample_end,
    output logic       m_sample_error
);

    logic       pend_valid_reg;
    logic [7:0] pend_data_reg;
    logic       m_valid_reg;
    logic [7:0] m_data_reg;
    logic       m_dv_reg;
    logic       m_end_reg;
    logic       m_err_reg;

    logic       load;
    logic [7:0] ld_data;
    logic       ld_dv;

    assign out_free = !m_valid_reg || m_ready;
    // a parked byte only goes out once the next one replaces it or the sample ends
    assign load = res.push && (!res.park || pend_valid_reg);

    always_comb begin
        if (res.sample_end) begin
            ld_data = pend_valid_reg ? pend_data_reg : 8'h00;
            ld_dv   = pend_valid_reg;
        end else if (res.park) begin
            ld_data = pend_data_reg;
            ld_dv   = 1'b1;
        end else begin
            ld_data = res.data;
            ld_dv   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (res.push && res.park) begin
                pend_valid_reg <= 1'b1;
            end else if (res.push && res.sample_end) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= ld_data;
            m_dv_reg   <= ld_dv;
            m_end_reg  <= res.sample_end;
            m_err_reg  <= res.sample_error;
        end
        if (res.push && res.park) begin
            pend_data_reg <= res.data;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_data_out     = m_data_reg;
    assign m_data_valid   = m_dv_reg;
    assign m_sample_end   = m_end_reg;
    assign m_sample_error = m_err_reg;

    a_err_with_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_err_reg |-> m_end_reg)
        else $error("error flag without sample end");

endmodule

[rtl/length_prefixed_to_start_code_nal.sv]
// ----------------------------------------------------------------------------
// length_prefixed_to_start_code_nal
// Converts length-prefixed NAL samples to start-code form, one byte a cycle unless m_ready stalls the output.
// ----------------------------------------------------------------------------
// Bytes of a sample arrive one per request with a last flag. Samples whose
// first four bytes already begin with a 00 00 01 or 00 00 00 01 start code
// pass through unchanged; otherwise each big-endian length prefix
// (cfg_wr_data bytes, 0 acts as 1 and 5..7 as 4) is replaced by 00 00 00 01.
// Pass-through and payload bytes go straight out. The fourth byte of a
// sample also latches the head and replays the held head bytes, each start
// code adds the bytes 00 00 00 01, and the end of every sample takes a flush
// step to attach sample_end and sample_error to its final result. The single
// output register issues one result per cycle unless m_ready stalls it.
// Samples flagged with sample_error must be dropped downstream.
// ----------------------------------------------------------------------------
module length_prefixed_to_start_code_nal
    import lpsc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_data_in,
    input  logic             s_last_in,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_data_out,
    output logic             m_data_valid,
    output logic             m_sample_end,
    output logic             m_sample_error
);

    logic [CFG_W-1:0]     nal_len_bytes_reg;
    logic [PFX_CNT_W-1:0] pfx_size;
    logic                 out_free;
    lpsc_res_t            res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nal_len_bytes_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            nal_len_bytes_reg <= cfg_wr_data;
        end
    end

    // clamp the prefix size into 1..4
    always_comb begin
        if (nal_len_bytes_reg < PFX_MIN) begin
            pfx_size = PFX_MIN;
        end else if (nal_len_bytes_reg > PFX_MAX) begin
            pfx_size = PFX_MAX;
        end else begin
            pfx_size = nal_len_bytes_reg;
        end
    end

    lpsc_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data_in (s_data_in),
        .s_last_in (s_last_in),
        .pfx_size  (pfx_size),
        .out_free  (out_free),
        .res       (res)
    );

    lpsc_out_stage u_out_stage (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .res            (res),
        .out_free       (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data_out     (m_data_out),
        .m_data_valid   (m_data_valid),
        .m_sample_end   (m_sample_end),
        .m_sample_error (m_sample_error)
    );

endmodule
